[rtl/gvd_pkg.sv]
// Package for the gaussian vertex deformation core: widths, register
// indexes and the exp table entry function. No dependencies.
package gvd_pkg;

	localparam int unsigned EXP_DEPTH_DEF = 256;
	localparam int unsigned CFG_W = 48;

	typedef logic signed [15:0] q12_t;

	typedef enum logic [2:0] {
		REG_CYL_MODE  = 3'd0,
		REG_CENTER    = 3'd1,
		REG_DIR       = 3'd2,
		REG_AXIS      = 3'd3,
		REG_INV_DIR   = 3'd4,
		REG_INV_WIDTH = 3'd5
	} cfg_reg_t;

	// exp(-16*i/depth) in Q16: Taylor sum in Q30, then squared four times
	function automatic logic [16:0] exp_entry(int unsigned i, int unsigned depth);
		logic [63:0]        u;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] sum;
		u    = (64'(i) << 30) / 64'(depth);
		term = 64'd1 << 30;
		sum  = $signed(term);
		for (int n = 1; n < 15; n++) begin
			term = ((term * u) >> 30) / 64'(n);
			if (n % 2 == 1) sum = sum - $signed(term);
			else            sum = sum + $signed(term);
		end
		v = $unsigned(sum);
		for (int k = 0; k < 4; k++) v = (v * v + (64'd1 << 29)) >> 30;
		return 17'((v + (64'd1 << 13)) >> 14);
	endfunction

endpackage

[rtl/gvd_vtx_if.sv]
// Stream channel interfaces: vertex in, displaced vertex out.
// Depends on gvd_pkg for the coordinate type.
interface gvd_vtx_if import gvd_pkg::*; ();
	logic valid;
	logic ready;
	q12_t pos_x;
	q12_t pos_y;
	q12_t pos_z;
	modport source (output valid, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface gvd_res_if import gvd_pkg::*; ();
	logic valid;
	logic ready;
	q12_t new_x;
	q12_t new_y;
	q12_t new_z;
	logic clipped;
	modport source (output valid, new_x, new_y, new_z, clipped, input ready);
	modport sink (input valid, new_x, new_y, new_z, clipped, output ready);
endinterface

[rtl/gvd_offset.sv]
// Stages 1-4: offset from center, optional removal of the axis component.
// Depends on gvd_pkg.
module gvd_offset import gvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  q12_t               p [3],
	input  q12_t               ctr [3],
	input  q12_t               ax [3],
	input  logic               cyl,
	output logic               v_out,
	output q12_t               p_out [3],
	output logic signed [27:0] c_out [3]
);
	logic               v_s1, v_s2, v_s3, v_s4;
	q12_t               p_s1 [3], p_s2 [3], p_s3 [3], p_s4 [3];
	logic signed [16:0] c_s1 [3], c_s2 [3], c_s3 [3];
	logic signed [32:0] ca_s2 [3];
	logic signed [22:0] t_s3;
	logic signed [27:0] c_s4 [3];
	logic signed [35:0] tsum;
	logic signed [38:0] ta [3];
	logic signed [39:0] tr [3];

	always_comb begin
		tsum = 36'(ca_s2[0]) + 36'(ca_s2[1]) + 36'(ca_s2[2]) + 36'sd2048;
		for (int i = 0; i < 3; i++) begin
			ta[i] = 39'(t_s3) * 39'(ax[i]);
			tr[i] = (40'(ta[i]) + 40'sd2048) >>> 12;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i]  <= p[i];
				c_s1[i]  <= 17'(p[i]) - 17'(ctr[i]);
				p_s2[i]  <= p_s1[i];
				c_s2[i]  <= c_s1[i];
				ca_s2[i] <= 33'(c_s1[i]) * 33'(ax[i]);
				p_s3[i]  <= p_s2[i];
				c_s3[i]  <= c_s2[i];
				p_s4[i]  <= p_s3[i];
				c_s4[i]  <= cyl ? 28'(c_s3[i]) - 28'(tr[i]) : 28'(c_s3[i]);
			end
			t_s3 <= 23'(tsum >>> 12);
		end
	end

	assign v_out = v_s4;
	assign p_out = p_s4;
	assign c_out = c_s4;
endmodule

[rtl/gvd_dist.sv]
// Stages 5-12: remove the component along the direction, squared distance.
// Depends on gvd_pkg.
module gvd_dist import gvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  q12_t               p [3],
	input  logic signed [27:0] c [3],
	input  q12_t               d [3],
	input  logic [31:0]        inv_dir,
	output logic               v_out,
	output q12_t               p_out [3],
	output logic [31:0]        d2_out
);
	localparam int NS = 8;
	localparam logic signed [30:0] QLIM = 31'sh3FFF_FFFF;

	logic               v_q [NS];
	q12_t               p_q [NS][3];
	logic signed [27:0] c_s5 [3], c_s6 [3], c_s7 [3], c_s8 [3], c_s9 [3];
	logic signed [43:0] cd_s5 [3];
	logic signed [34:0] dd_s6;
	logic signed [51:0] mh_s7, ml_s7;
	logic signed [51:0] k_s8;
	logic signed [67:0] kd_s9 [3];
	logic signed [30:0] q_s10 [3];
	logic [60:0]        qq_s11 [3];
	logic [31:0]        d2_s12;

	logic signed [46:0] dsum;
	logic signed [68:0] kprod;
	logic signed [68:0] kr [3];
	logic signed [57:0] qv [3];
	logic signed [61:0] qsq [3];
	logic [62:0]        qqsum;
	logic [50:0]        d2w;

	always_comb begin
		dsum  = 47'(cd_s5[0]) + 47'(cd_s5[1]) + 47'(cd_s5[2]) + 47'sd2048;
		kprod = (69'(mh_s7) <<< 16) + 69'(ml_s7) + 69'sd32768;
		for (int i = 0; i < 3; i++) begin
			kr[i]  = (69'(kd_s9[i]) + 69'sd2048) >>> 12;
			qv[i]  = 58'(c_s9[i]) - 58'(kr[i]);
			qsq[i] = 62'(q_s10[i]) * 62'(q_s10[i]);
		end
		qqsum = 63'(qq_s11[0]) + 63'(qq_s11[1]) + 63'(qq_s11[2]);
		d2w   = qqsum[62:12];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
		end else if (en) begin
			v_q[0] <= v_in;
			for (int s = 1; s < NS; s++) v_q[s] <= v_q[s-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q[0] <= p;
			for (int s = 1; s < NS; s++) p_q[s] <= p_q[s-1];
			for (int i = 0; i < 3; i++) begin
				c_s5[i]  <= c[i];
				cd_s5[i] <= 44'(c[i]) * 44'(d[i]);
				c_s6[i]  <= c_s5[i];
				c_s7[i]  <= c_s6[i];
				c_s8[i]  <= c_s7[i];
				c_s9[i]  <= c_s8[i];
				kd_s9[i] <= 68'(k_s8) * 68'(d[i]);
				if (qv[i] > 58'(QLIM))       q_s10[i] <= QLIM;
				else if (qv[i] < -58'(QLIM)) q_s10[i] <= -QLIM;
				else                         q_s10[i] <= 31'(qv[i]);
				qq_s11[i] <= qsq[i][60:0];
			end
			dd_s6  <= 35'(dsum >>> 12);
			mh_s7  <= 52'(dd_s6) * $signed({1'b0, inv_dir[31:16]});
			ml_s7  <= 52'(dd_s6) * $signed({1'b0, inv_dir[15:0]});
			k_s8   <= 52'(kprod >>> 16);
			d2_s12 <= (|d2w[50:32]) ? 32'hFFFF_FFFF : d2w[31:0];
		end
	end

	assign v_out  = v_q[NS-1];
	assign p_out  = p_q[NS-1];
	assign d2_out = d2_s12;
endmodule

[rtl/gvd_bump.sv]
// Stages 13-19: exp table lookup, scaled displacement, saturating add.
// Depends on gvd_pkg for exp_entry.
module gvd_bump import gvd_pkg::*; #(
	parameter int unsigned EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_in,
	input  q12_t        p [3],
	input  logic [31:0] d2,
	input  q12_t        d [3],
	input  logic [31:0] inv_w,
	output logic        v_out,
	output q12_t        new_out [3],
	output logic        clip_out
);
	localparam int NS = 7;
	localparam int IW = $clog2(EXP_TABLE_DEPTH);
	localparam int MW = 31 + IW + 1;

	typedef logic [16:0] rom_t [EXP_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) r[i] = exp_entry(i, EXP_TABLE_DEPTH);
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic               v_q [NS];
	q12_t               p_q [NS-1][3];
	logic [63:0]        arg_s13;
	logic [IW-1:0]      idx_s14;
	logic               far_s14;
	logic [16:0]        g_s15;
	logic [48:0]        gi_s16;
	logic [32:0]        s_s17;
	logic signed [49:0] sd_s18 [3];
	q12_t               nv_s19 [3];
	logic               clip_s19;

	logic [MW-1:0]      idx_full;
	logic [IW-1:0]      idx_c;
	logic [49:0]        gr;
	logic signed [50:0] sr [3];
	logic signed [35:0] nv [3];
	logic               sat [3];

	always_comb begin
		idx_full = MW'(arg_s13[30:0]) * MW'(EXP_TABLE_DEPTH);
		idx_c    = (idx_full[MW-1:31] >= (IW+1)'(EXP_TABLE_DEPTH)) ?
			IW'(EXP_TABLE_DEPTH - 1) : idx_full[30+IW:31];
		gr = 50'(gi_s16) + 50'd32768;
		for (int i = 0; i < 3; i++) begin
			sr[i]  = (51'(sd_s18[i]) + 51'sd32768) >>> 16;
			nv[i]  = 36'(p_q[NS-2][i]) + 36'(sr[i]);
			sat[i] = (nv[i] > 36'sd32767) || (nv[i] < -36'sd32768);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
		end else if (en) begin
			v_q[0] <= v_in;
			for (int s = 1; s < NS; s++) v_q[s] <= v_q[s-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q[0] <= p;
			for (int s = 1; s < NS-1; s++) p_q[s] <= p_q[s-1];
			arg_s13 <= 64'(d2) * 64'(inv_w);
			idx_s14 <= idx_c;
			far_s14 <= |arg_s13[63:31];
			g_s15   <= far_s14 ? 17'd0 : ROM[idx_s14];
			gi_s16  <= 49'(g_s15) * 49'(inv_w);
			s_s17   <= 33'(gr >> 16);
			for (int i = 0; i < 3; i++) begin
				sd_s18[i] <= $signed({1'b0, s_s17}) * 50'(d[i]);
				if (nv[i] > 36'sd32767)       nv_s19[i] <= 16'sh7FFF;
				else if (nv[i] < -36'sd32768) nv_s19[i] <= -16'sh8000;
				else                          nv_s19[i] <= 16'(nv[i]);
			end
			clip_s19 <= sat[0] | sat[1] | sat[2];
		end
	end

	assign v_out    = v_q[NS-1];
	assign new_out  = nv_s19;
	assign clip_out = clip_s19;
endmodule

[rtl/gaussian_vertex_deformation_core.sv]
// Top level of the gaussian vertex deformation core: config registers,
// pipeline control. Depends on gvd_pkg, gvd_vtx_if/gvd_res_if, gvd_offset,
// gvd_dist and gvd_bump.
//
// Usage:
//   in_vtx  (sink)  : one vertex per transfer, pos_x/y/z signed Q4.12.
//   out_res (source): displaced vertex new_x/y/z, saturated, plus clipped.
//   cfg_we/cfg_idx/cfg_data: register writes (mode, center, dir, axis,
//   1/|dir|^2, 1/width^2); write only while the pipe is empty.
// Throughput: one vertex per cycle unless the output stalls; every
// stage holds one vertex and valid bits travel along with the data.
// The exp table is a constant ROM of EXP_TABLE_DEPTH entries, read in
// one registered stage; there is no clearing pass after reset.
// Reset clears all valid bits and the config registers to zero.
// Stall: when out_res.ready is low and a result is held at the output,
// the whole pipe freezes and in_vtx.ready drops; nothing is lost or
// repeated, and empty output slots let the pipe keep moving.
module gaussian_vertex_deformation_core import gvd_pkg::*; #(
	parameter int unsigned EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	gvd_vtx_if.sink          in_vtx,
	gvd_res_if.source        out_res,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);
	logic        cyl_q;
	logic [47:0] center_q, dir_q, axis_q;
	logic [31:0] inv_dir_q, inv_w_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_q     <= 1'b0;
			center_q  <= '0;
			dir_q     <= '0;
			axis_q    <= '0;
			inv_dir_q <= '0;
			inv_w_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_CYL_MODE:  cyl_q     <= cfg_data[0];
				REG_CENTER:    center_q  <= cfg_data[47:0];
				REG_DIR:       dir_q     <= cfg_data[47:0];
				REG_AXIS:      axis_q    <= cfg_data[47:0];
				REG_INV_DIR:   inv_dir_q <= cfg_data[31:0];
				REG_INV_WIDTH: inv_w_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	q12_t ctr [3], dv [3], av [3], pin [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ctr[i] = center_q[16*i +: 16];
			dv[i]  = dir_q[16*i +: 16];
			av[i]  = axis_q[16*i +: 16];
		end
		pin[0] = in_vtx.pos_x;
		pin[1] = in_vtx.pos_y;
		pin[2] = in_vtx.pos_z;
	end

	// global advance: the pipe moves unless a held result is not taken
	logic en;
	logic v_res;
	assign en           = !v_res || out_res.ready;
	assign in_vtx.ready = en;

	logic               v_off, v_dist;
	q12_t               p_off [3], p_dist [3], nv [3];
	logic signed [27:0] c_off [3];
	logic [31:0]        d2;
	logic               clip;

	gvd_offset u_offset (
		.clk, .arst_n, .en,
		.v_in  (in_vtx.valid),
		.p     (pin),
		.ctr   (ctr),
		.ax    (av),
		.cyl   (cyl_q),
		.v_out (v_off),
		.p_out (p_off),
		.c_out (c_off)
	);

	gvd_dist u_dist (
		.clk, .arst_n, .en,
		.v_in    (v_off),
		.p       (p_off),
		.c       (c_off),
		.d       (dv),
		.inv_dir (inv_dir_q),
		.v_out   (v_dist),
		.p_out   (p_dist),
		.d2_out  (d2)
	);

	gvd_bump #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_bump (
		.clk, .arst_n, .en,
		.v_in     (v_dist),
		.p        (p_dist),
		.d2       (d2),
		.d        (dv),
		.inv_w    (inv_w_q),
		.v_out    (v_res),
		.new_out  (nv),
		.clip_out (clip)
	);

	assign out_res.valid   = v_res;
	assign out_res.new_x   = nv[0];
	assign out_res.new_y   = nv[1];
	assign out_res.new_z   = nv[2];
	assign out_res.clipped = clip;
endmodule
